// ===== rtl/sit_pkg.sv =====
package sit_pkg;

    // Field widths of one record
    localparam int OFS_W = 24;
    localparam int SIZE_W = 16;
    localparam int PAY_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W = 2;

    // Midpoint sums 2*offset + size need two more bits than the offset
    localparam int MID_W = OFS_W + 2;
    // Sum of two sizes
    localparam int SPAN_W = SIZE_W + 1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Item modes
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic [PAY_W-1:0]  payload;
        logic              is_rle;
        logic [SIZE_W-1:0] size;
        logic [OFS_W-1:0]  offset;
    } rec_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;  // evaluate the new record against the stored one
        logic commit;   // shift or load the entry
    } cell_ctrl_t;

endpackage

// ===== rtl/sorted_interval_table_insert.sv =====
// Sorted, non-overlapping table of patch records (offset, size, rle flag, payload).
// Input channel s_*: one item per handshake; s_tuser selects add (0) or read (1).
// An add item is checked against every stored record at once; if its closed
// interval meets none and the table has room, it is inserted in offset order.
// A read item returns the record at read_index, or a range status.
// Result channel m_*: exactly one item per input item, status on m_tuser, the
// entry count after the item and the read record on m_tdata.
// Timing: an item passes accept, compare and apply steps; the result is loaded
// in the apply step, and the next item is taken only once that step is done.
// The compare step registers one flag pair per cell; the apply step reduces
// the hit flags and shifts the whole row at once.
// While a result is waiting, the next item is still accepted and compared; its
// apply step holds until the receiver takes the pending result.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// item or result; stored records are not cleared.
module sorted_interval_table_insert #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rec_offset[23:0], rec_size[39:24], rec_is_rle[40], rec_payload[72:41],
    // read_index[78:73], zero[79]
    input  logic [79:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // entry_count[6:0], out_offset[30:7], out_size[46:31], out_is_rle[47],
    // out_payload[79:48]
    output logic [79:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);
    import sit_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             m_tvalid_reg;
    logic [79:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    rec_t             item_reg;
    logic             mode_reg;
    logic [IDX_W-1:0] idx_reg;
    rec_t             rd_reg;
    logic             rd_bad_reg;

    cell_ctrl_t       ctrl;
    rec_t             cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_open;
    logic [TABLE_DEPTH-1:0] cell_hit;
    logic [TABLE_DEPTH-1:0] cell_occ;

    rec_t             rd_sel;
    logic             rd_bad;
    logic             hit_any;
    logic             full;
    logic             out_free;
    logic [1:0]       status;
    logic             do_insert;

    // Row of cells, each but the first fed by its left neighbor; the first is fed the new item
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        assign cell_occ[k] = (32'(fill_reg) > k);
        if (k == 0) begin : g_first
            sit_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .new_rec   (item_reg),
                .occupied  (cell_occ[k]),
                .left_open (1'b0),
                .left_rec  (item_reg),
                .entry     (cell_entry[k]),
                .open      (cell_open[k]),
                .hit       (cell_hit[k])
            );
        end else begin : g_rest
            sit_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .new_rec   (item_reg),
                .occupied  (cell_occ[k]),
                .left_open (cell_open[k-1]),
                .left_rec  (cell_entry[k-1]),
                .entry     (cell_entry[k]),
                .open      (cell_open[k]),
                .hit       (cell_hit[k])
            );
        end
    end

    // Select the entry addressed by a read item
    always_comb begin
        rd_sel = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (32'(idx_reg) == k) begin
                rd_sel = cell_entry[k];
            end
        end
        rd_bad = (32'(idx_reg) >= 32'(fill_reg)) || (32'(idx_reg) >= TABLE_DEPTH);
    end

    // Decide the outcome of the item in the apply step
    always_comb begin
        hit_any = |cell_hit;
        full = (fill_reg == CNT_W'(TABLE_DEPTH));
        out_free = !m_tvalid_reg || m_tready;
        do_insert = 1'b0;
        fill_next = fill_reg;
        if (mode_reg == MODE_ADD) begin
            if (hit_any) begin
                status = ST_OVERLAP;
            end else if (full) begin
                status = ST_FULL;
            end else begin
                status = ST_OK;
                do_insert = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
            end
        end else begin
            status = rd_bad_reg ? ST_RANGE : ST_OK;
        end
        ctrl.capture = (state_reg == S_CMP);
        ctrl.commit = (state_reg == S_APPLY) && out_free && do_insert;
    end

    // Sequencer, fill count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_APPLY) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) begin
                        fill_reg <= fill_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (m_tvalid_reg && m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the item on accept
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            item_reg.offset <= s_tdata[23:0];
            item_reg.size <= s_tdata[39:24];
            item_reg.is_rle <= s_tdata[40];
            item_reg.payload <= s_tdata[72:41];
            idx_reg <= s_tdata[78:73];
            mode_reg <= s_tuser;
        end
    end

    // Register the read data in the compare step
    always_ff @(posedge aclk) begin
        if (state_reg == S_CMP) begin
            rd_reg <= rd_sel;
            rd_bad_reg <= rd_bad;
        end
    end

    // Load the result payload; record fields are zero unless a read succeeds
    always_ff @(posedge aclk) begin
        if (state_reg == S_APPLY && out_free) begin
            m_tuser_reg <= status;
            m_tdata_reg[6:0] <= CNT_OUT_W'(fill_next);
            if (mode_reg == MODE_READ && !rd_bad_reg) begin
                m_tdata_reg[30:7] <= rd_reg.offset;
                m_tdata_reg[46:31] <= rd_reg.size;
                m_tdata_reg[47] <= rd_reg.is_rle;
                m_tdata_reg[79:48] <= rd_reg.payload;
            end else begin
                m_tdata_reg[79:7] <= '0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== rtl/sit_cell.sv =====
module sit_cell (
    input  logic               aclk,
    input  sit_pkg::cell_ctrl_t ctrl,
    input  sit_pkg::rec_t      new_rec,
    input  logic               occupied,
    input  logic               left_open,
    input  sit_pkg::rec_t      left_rec,
    output sit_pkg::rec_t      entry,
    output logic               open,
    output logic               hit
);
    import sit_pkg::*;

    rec_t entry_reg;
    logic open_reg;
    logic hit_reg;

    logic [MID_W-1:0]  mid_new;
    logic [MID_W-1:0]  mid_old;
    logic [MID_W-1:0]  mid_diff;
    logic [SPAN_W-1:0] span;
    logic              meets;

    // Closed-interval overlap test on doubled midpoints
    always_comb begin
        mid_new = {new_rec.offset, 1'b0} + MID_W'(new_rec.size);
        mid_old = {entry_reg.offset, 1'b0} + MID_W'(entry_reg.size);
        mid_diff = (mid_new > mid_old) ? (mid_new - mid_old) : (mid_old - mid_new);
        span = SPAN_W'(new_rec.size) + SPAN_W'(entry_reg.size);
        meets = (mid_diff <= MID_W'(span));
    end

    // Hold the flags of this item; an empty cell is always open for insertion
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            hit_reg <= occupied && meets;
            open_reg <= !occupied || (entry_reg.offset > new_rec.offset);
        end
    end

    // Shift up from the left neighbor, or take the new record at the insert point
    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            if (left_open) begin
                entry_reg <= left_rec;
            end else if (open_reg) begin
                entry_reg <= new_rec;
            end
        end
    end

    assign entry = entry_reg;
    assign open = open_reg;
    assign hit = hit_reg;

endmodule
